[rtl/active_interval_set_sweep_defines.svh]
// ---------------------------------------------------------------------------
// active_interval_set_sweep_defines
// Assertion macros for the interval sweep block.
// ---------------------------------------------------------------------------
`ifndef ACTIVE_INTERVAL_SET_SWEEP_DEFINES_SVH
`define ACTIVE_INTERVAL_SET_SWEEP_DEFINES_SVH

`ifndef SYNTH
`define AISS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AISS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AISS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define AISS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[rtl/aiss_pkg.sv]
// ---------------------------------------------------------------------------
// aiss_pkg
// Shared widths, defaults, codes and state type for the interval sweep.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aiss_pkg;

    localparam int MAX_ACTIVE_DEF = 32;
    localparam int ID_COUNT_DEF   = 65536;
    localparam int MEMBER_ID_W    = 16;
    localparam int DATA_W         = 32;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } state_t;

endpackage

[rtl/aiss_cell.sv]
// ---------------------------------------------------------------------------
// aiss_cell
// One slot of the active set: holds an id and end, shifts toward the head.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aiss_cell #(
    parameter int IDW = 16
) (
    input  logic                      aclk,
    input  logic                      shift_en,
    input  logic                      load_en,
    input  logic [IDW-1:0]            nbr_id,
    input  logic [aiss_pkg::DATA_W-1:0] nbr_end,
    input  logic [IDW-1:0]            load_id,
    input  logic [aiss_pkg::DATA_W-1:0] load_end,
    output logic [IDW-1:0]            id,
    output logic [aiss_pkg::DATA_W-1:0] end_val
);
    import aiss_pkg::*;

    logic [IDW-1:0]    id_reg;
    logic [IDW-1:0]    id_next;
    logic [DATA_W-1:0] end_reg;
    logic [DATA_W-1:0] end_next;

    always_comb begin
        id_next  = id_reg;
        end_next = end_reg;
        if (load_en) begin
            id_next  = load_id;
            end_next = load_end;
        end else if (shift_en) begin
            id_next  = nbr_id;
            end_next = nbr_end;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg  <= id_next;
        end_reg <= end_next;
    end

    assign id      = id_reg;
    assign end_val = end_reg;

endmodule

[rtl/active_interval_set_sweep.sv]
// ---------------------------------------------------------------------------
// active_interval_set_sweep
// Sweep-line keeper of the open interval set, held in a chain of cells.
// ---------------------------------------------------------------------------
//  channel | ports                                   | dir
//  --------+-----------------------------------------+-----
//  input   | s_valid s_ready s_op s_point_value      | in
//          | s_end_value                             |
//  result  | m_valid m_ready m_member_id m_from_start| out
//          | m_run_last m_overflow                   |
//
//  Start word: held off while a walk runs or the output register is full.
//  Point word: the chain shifts one cell per cycle, when not stalled,
//  toward the head, compacting survivors behind the unvisited entries.
//  Result backpressure stalls the walk only when a survivor must be sent.
//  Reset clears count, point and id counter; no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "active_interval_set_sweep_defines.svh"

module active_interval_set_sweep #(
    parameter int MAX_ACTIVE = aiss_pkg::MAX_ACTIVE_DEF,
    parameter int ID_COUNT   = aiss_pkg::ID_COUNT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic signed [aiss_pkg::DATA_W-1:0]   s_point_value,
    input  logic signed [aiss_pkg::DATA_W-1:0]   s_end_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [aiss_pkg::MEMBER_ID_W-1:0]     m_member_id,
    output logic                                 m_from_start,
    output logic                                 m_run_last,
    output logic                                 m_overflow
);
    import aiss_pkg::*;

    localparam int CW  = $clog2(MAX_ACTIVE + 1);
    localparam int IDW = $clog2(ID_COUNT);

    state_t state_reg, state_next;

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      remain_reg, remain_next;
    logic [CW-1:0]      wp_reg, wp_next;
    logic [DATA_W-1:0]  point_reg, point_next;
    logic [IDW-1:0]     nid_reg, nid_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [IDW-1:0]     pend_id_reg, pend_id_next;

    logic               m_valid_reg, m_valid_next;
    logic [IDW-1:0]     m_id_reg, m_id_next;
    logic               m_fs_reg, m_fs_next;
    logic               m_last_reg, m_last_next;
    logic               m_ovf_reg, m_ovf_next;

    logic [IDW-1:0]     cell_id  [MAX_ACTIVE];
    logic [DATA_W-1:0]  cell_end [MAX_ACTIVE];
    logic [MAX_ACTIVE-1:0] cell_load;

    logic               slot_free;
    logic               accept;
    logic               is_start;
    logic               is_point;
    logic               start_keep;
    logic               full;
    logic               keep;
    logic               walking;
    logic               step;
    logic [IDW-1:0]     load_id;
    logic [DATA_W-1:0]  load_end;

    assign slot_free  = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE) && ((s_op == OP_POINT) || slot_free);
    assign accept     = s_valid && s_ready;
    assign is_start   = accept && (s_op == OP_START);
    assign is_point   = accept && (s_op == OP_POINT);
    assign start_keep = $unsigned(s_end_value) != point_reg;
    assign full       = count_reg == CW'(MAX_ACTIVE);
    assign keep       = cell_end[0] != point_reg;
    assign walking    = (state_reg == ST_WALK) && (remain_reg != '0);
    assign step       = walking && !(keep && pend_valid_reg && !slot_free);
    assign load_id    = step ? cell_id[0] : nid_reg;
    assign load_end   = step ? cell_end[0] : $unsigned(s_end_value);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ACTIVE; gi++) begin : g_cell
            assign cell_load[gi] = (step && keep && (wp_reg == CW'(gi)))
                || (is_start && start_keep && !full && (count_reg == CW'(gi)));
            if (gi < MAX_ACTIVE - 1) begin : g_mid
                aiss_cell #(.IDW(IDW)) u_cell (
                    .aclk     (aclk),
                    .shift_en (step),
                    .load_en  (cell_load[gi]),
                    .nbr_id   (cell_id[gi+1]),
                    .nbr_end  (cell_end[gi+1]),
                    .load_id  (load_id),
                    .load_end (load_end),
                    .id       (cell_id[gi]),
                    .end_val  (cell_end[gi])
                );
            end else begin : g_tail
                aiss_cell #(.IDW(IDW)) u_cell (
                    .aclk     (aclk),
                    .shift_en (1'b0),
                    .load_en  (cell_load[gi]),
                    .nbr_id   (cell_id[gi]),
                    .nbr_end  (cell_end[gi]),
                    .load_id  (load_id),
                    .load_end (load_end),
                    .id       (cell_id[gi]),
                    .end_val  (cell_end[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        wp_next         = wp_reg;
        point_next      = point_reg;
        nid_next        = nid_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_id_next       = m_id_reg;
        m_fs_next       = m_fs_reg;
        m_last_next     = m_last_reg;
        m_ovf_next      = m_ovf_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (is_point) begin
                    point_next      = $unsigned(s_point_value);
                    remain_next     = count_reg;
                    wp_next         = count_reg - CW'(1);
                    pend_valid_next = 1'b0;
                    state_next      = ST_WALK;
                end else if (is_start) begin
                    nid_next = (nid_reg == IDW'(ID_COUNT - 1)) ? '0 : nid_reg + IDW'(1);
                    if (start_keep) begin
                        m_valid_next = 1'b1;
                        m_id_next    = nid_reg;
                        m_fs_next    = 1'b1;
                        m_last_next  = 1'b1;
                        m_ovf_next   = full;
                        if (!full) begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
            end
            ST_WALK: begin
                if (remain_reg != '0) begin
                    if (step) begin
                        remain_next = remain_reg - CW'(1);
                        if (keep) begin
                            if (pend_valid_reg) begin
                                m_valid_next = 1'b1;
                                m_id_next    = pend_id_reg;
                                m_fs_next    = 1'b0;
                                m_last_next  = 1'b0;
                                m_ovf_next   = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_id_next    = cell_id[0];
                        end else begin
                            count_next = count_reg - CW'(1);
                            wp_next    = wp_reg - CW'(1);
                        end
                    end
                end else if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (slot_free) begin
                    m_valid_next    = 1'b1;
                    m_id_next       = pend_id_reg;
                    m_fs_next       = 1'b0;
                    m_last_next     = 1'b1;
                    m_ovf_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            remain_reg     <= '0;
            point_reg      <= '0;
            nid_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            remain_reg     <= remain_next;
            point_reg      <= point_next;
            nid_reg        <= nid_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wp_reg      <= wp_next;
        pend_id_reg <= pend_id_next;
        m_id_reg    <= m_id_next;
        m_fs_reg    <= m_fs_next;
        m_last_reg  <= m_last_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_member_id  = MEMBER_ID_W'(m_id_reg);
    assign m_from_start = m_fs_reg;
    assign m_run_last   = m_last_reg;
    assign m_overflow   = m_ovf_reg;

    `AISS_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(MAX_ACTIVE))
    `AISS_ASSERT_IMPL(a_walk_blocks_input, aclk, aresetn, state_reg == ST_WALK, !s_ready)
    `AISS_ASSERT_IMPL(a_start_is_last, aclk, aresetn, m_valid_reg && m_fs_reg, m_last_reg)
    `AISS_ASSERT_IMPL(a_ovf_from_start, aclk, aresetn, m_valid_reg && m_ovf_reg, m_fs_reg)
    `AISS_ASSERT_NEXT(a_walk_progress, aclk, aresetn, step, remain_reg == $past(remain_reg) - CW'(1))

endmodule
